@@ rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned WORD_W    = 32;

    localparam logic signed [WORD_W-1:0] NONE_WORD = -32'sd1;

    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_QUERY      = 3'd4
    } t_mode;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic                     pop_failed;
        logic                     push_dropped;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
    } t_deq_res;

endpackage

@@ rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring indices, occupancy, cached end words and inner-word prefetch with
// write bypass; computes the result of the current transaction.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
    parameter int unsigned IDX_W = $clog2(DEPTH),
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  deq_pkg::t_mode                   i_mode,
    input  logic signed [deq_pkg::WORD_W-1:0] i_value,
    input  logic [deq_pkg::WORD_W-1:0]       i_rdata_a,
    input  logic [deq_pkg::WORD_W-1:0]       i_rdata_b,
    output logic                             o_we,
    output logic [IDX_W-1:0]                 o_waddr,
    output logic [deq_pkg::WORD_W-1:0]       o_wdata,
    output logic [IDX_W-1:0]                 o_raddr_a,
    output logic [IDX_W-1:0]                 o_raddr_b,
    output deq_pkg::t_deq_res                o_res,
    output logic [CNT_W-1:0]                 o_count
);
    import deq_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] f_inc(input logic [IDX_W-1:0] idx);
        f_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] f_dec(input logic [IDX_W-1:0] idx);
        f_dec = (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    logic [IDX_W-1:0]         r_front_idx, n_front_idx;
    logic [IDX_W-1:0]         r_back_idx,  n_back_idx;
    logic [CNT_W-1:0]         r_count,     n_count;
    logic signed [WORD_W-1:0] r_front_val, n_front_val;
    logic signed [WORD_W-1:0] r_back_val,  n_back_val;
    logic                     r_byp_a,     n_byp_a;
    logic                     r_byp_b,     n_byp_b;
    logic [WORD_W-1:0]        r_byp_data;
    logic [WORD_W-1:0]        front2;
    logic [WORD_W-1:0]        back2;
    logic                     is_full;
    logic                     is_empty;

    assign front2   = r_byp_a ? r_byp_data : i_rdata_a;
    assign back2    = r_byp_b ? r_byp_data : i_rdata_b;
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_front_idx         = r_front_idx;
        n_back_idx          = r_back_idx;
        n_count             = r_count;
        n_front_val         = r_front_val;
        n_back_val          = r_back_val;
        o_we                = 1'b0;
        o_waddr             = r_back_idx;
        o_wdata             = i_value;
        o_res.popped        = NONE_WORD;
        o_res.pop_failed    = 1'b0;
        o_res.push_dropped  = 1'b0;
        if (i_accept) begin
            case (i_mode)
                MODE_PUSH_BACK: begin
                    if (is_full) begin
                        o_res.push_dropped = 1'b1;
                    end else begin
                        n_back_idx = f_inc(r_back_idx);
                        o_we       = 1'b1;
                        o_waddr    = n_back_idx;
                        n_back_val = i_value;
                        n_count    = r_count + CNT_W'(1);
                        if (is_empty) begin
                            n_front_val = i_value;
                        end
                    end
                end
                MODE_PUSH_FRONT: begin
                    if (is_full) begin
                        o_res.push_dropped = 1'b1;
                    end else begin
                        n_front_idx = f_dec(r_front_idx);
                        o_we        = 1'b1;
                        o_waddr     = n_front_idx;
                        n_front_val = i_value;
                        n_count     = r_count + CNT_W'(1);
                        if (is_empty) begin
                            n_back_val = i_value;
                        end
                    end
                end
                MODE_POP_FRONT: begin
                    if (is_empty) begin
                        o_res.pop_failed = 1'b1;
                    end else begin
                        o_res.popped = r_front_val;
                        n_front_idx  = f_inc(r_front_idx);
                        n_count      = r_count - CNT_W'(1);
                        n_front_val  = (r_count == CNT_W'(2)) ? r_back_val : front2;
                    end
                end
                MODE_POP_BACK: begin
                    if (is_empty) begin
                        o_res.pop_failed = 1'b1;
                    end else begin
                        o_res.popped = r_back_val;
                        n_back_idx   = f_dec(r_back_idx);
                        n_count      = r_count - CNT_W'(1);
                        n_back_val   = (r_count == CNT_W'(2)) ? r_front_val : back2;
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.front_value = (n_count == '0) ? NONE_WORD : n_front_val;
        o_res.back_value  = (n_count == '0) ? NONE_WORD : n_back_val;
    end

    assign o_raddr_a = f_inc(n_front_idx);
    assign o_raddr_b = f_dec(n_back_idx);
    assign n_byp_a   = o_we && (o_waddr == o_raddr_a);
    assign n_byp_b   = o_we && (o_waddr == o_raddr_b);

    assign o_count           = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_idx <= '0;
            r_back_idx  <= LAST_IDX;
            r_count     <= '0;
            r_byp_a     <= 1'b0;
            r_byp_b     <= 1'b0;
        end else begin
            r_front_idx <= n_front_idx;
            r_back_idx  <= n_back_idx;
            r_count     <= n_count;
            r_byp_a     <= n_byp_a;
            r_byp_b     <= n_byp_b;
        end
        r_front_val <= n_front_val;
        r_back_val  <= n_back_val;
        r_byp_data  <= o_wdata;
    end

endmodule

@@ rtl/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit words in a ring RAM.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  command   | start / busy          | i_mode, i_value
//  result    | o_valid (strobe)      | o_popped, o_pop_failed, o_push_dropped,
//            |                       | o_count, o_is_empty, o_front_value,
//            |                       | o_back_value
//
//  One transaction per cycle; busy is always low. The result appears in the
//  cycle after the command, for one cycle. End words are cached in
//  registers and the RAM read ports prefetch the words next to each end,
//  so a pop needs no wait on the RAM. Synchronous active-low reset empties
//  the queue at once. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_mode,
    input  logic signed [deq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    output logic signed [deq_pkg::WORD_W-1:0] o_popped,
    output logic                              o_pop_failed,
    output logic                              o_push_dropped,
    output logic [CNT_W-1:0]                  o_count,
    output logic                              o_is_empty,
    output logic signed [deq_pkg::WORD_W-1:0] o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0] o_back_value
);
    import deq_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);

    logic              accept;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr_a;
    logic [IDX_W-1:0]  ram_raddr_b;
    logic [WORD_W-1:0] ram_rdata_a;
    logic [WORD_W-1:0] ram_rdata_b;
    t_deq_res          res;
    logic [CNT_W-1:0]  next_count;

    logic              r_valid;
    t_deq_res          r_res;
    logic [CNT_W-1:0]  r_count;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    deq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_mode    (t_mode'(i_mode)),
        .i_value   (i_value),
        .i_rdata_a (ram_rdata_a),
        .i_rdata_b (ram_rdata_b),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_raddr_a (ram_raddr_a),
        .o_raddr_b (ram_raddr_b),
        .o_res     (res),
        .o_count   (next_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
        if (accept) begin
            r_res   <= res;
            r_count <= next_count;
        end
    end

    assign o_valid        = r_valid;
    assign o_popped       = r_res.popped;
    assign o_pop_failed   = r_res.pop_failed;
    assign o_push_dropped = r_res.push_dropped;
    assign o_count        = r_count;
    assign o_is_empty     = (r_count == '0);
    assign o_front_value  = r_res.front_value;
    assign o_back_value   = r_res.back_value;

`ifndef SYNTHESIS
    a_valid_follows_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy))
        else $error("result strobe without a command");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(DEPTH)))
        else $error("occupancy exceeds depth");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_push_dropped) |-> (o_count == CNT_W'(DEPTH)))
        else $error("push dropped while not full");

    a_fail_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pop_failed) |-> (o_is_empty && (o_popped == NONE_WORD)))
        else $error("failed pop with entries present");
`endif

endmodule
